// ----- sv/rpp_pkg.sv -----
// Package for the RIPv2 packet parser: item types, protocol constants and
// result-queue sizing. No dependencies.
package rpp_pkg;

    // Protocol constants
    localparam int unsigned MAX_ENTRIES = 25;
    localparam int unsigned CNT_W       = 5;

    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  CMD_REQUEST   = 8'd1;
    localparam logic [7:0]  CMD_RESPONSE  = 8'd2;
    localparam logic [7:0]  RIP_VERSION   = 8'd2;
    localparam logic [15:0] FAMILY_NONE   = 16'd0;
    localparam logic [15:0] FAMILY_IP     = 16'd2;
    localparam logic [3:0]  IHL_MASK      = 4'hf;
    localparam logic [6:0]  UDP_HDR_BYTES = 7'd8;
    localparam logic [6:0]  RIP_HDR_BYTES = 7'd4;
    localparam logic [4:0]  ENTRY_BYTES   = 5'd20;
    localparam logic [31:0] METRIC_MAX    = 32'd16;

    // Byte positions within the IPv4 header
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_LEN_HI   = 16'd2;
    localparam logic [15:0] POS_LEN_LO   = 16'd3;
    localparam logic [15:0] POS_PROTO    = 16'd9;
    localparam logic [15:0] POS_SRC_FRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST = 16'd15;
    localparam logic [15:0] POS_MAX      = 16'hffff;

    // Byte offsets within a route entry
    localparam logic [4:0] ENT_TAG_END  = 5'd3;
    localparam logic [4:0] ENT_ADDR_END = 5'd7;
    localparam logic [4:0] ENT_MASK_END = 5'd11;

    // Result kinds
    localparam logic KIND_ROUTE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Result queue sizing
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
    // Room for the item in the input stage and one more, two results each
    localparam int unsigned Q_ACCEPT_MAX = QDEPTH - 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic             result_kind;
        logic [31:0]      route_addr;
        logic [31:0]      route_mask;
        logic [31:0]      next_hop;
        logic [31:0]      route_metric;
        logic             entry_ok;
        logic [CNT_W-1:0] entry_number;
        logic             packet_ok;
        logic [7:0]       rip_command;
        logic [CNT_W-1:0] entry_count;
    } t_out_item;

    // Results raised by one parsed byte: a route first, then a status
    typedef struct packed {
        logic      route_vld;
        logic      stat_vld;
        t_out_item route;
        t_out_item stat;
    } t_push;

endpackage

// ----- sv/rpp_parse.sv -----
// Per-byte parse logic and packet state of the RIPv2 packet parser.
// Depends on rpp_pkg.
module rpp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rpp_pkg::t_in_item i_item,
    output rpp_pkg::t_push    o_push
);
    import rpp_pkg::*;

    logic [15:0]      r_pos,   n_pos;
    logic [15:0]      r_tlen,  n_tlen;
    logic [5:0]       r_ihl,   n_ihl;
    logic [31:0]      r_src,   n_src;
    logic [7:0]       r_cmd,   n_cmd;
    logic [4:0]       r_ebi,   n_ebi;
    logic [CNT_W-1:0] r_seen,  n_seen;
    logic [31:0]      r_ws,    n_ws;
    logic [31:0]      r_addr,  n_addr;
    logic [31:0]      r_mask,  n_mask;
    logic             r_egood, n_egood;
    logic             r_bad,   n_bad;

    logic [7:0]  b;
    logic [15:0] rs;
    logic [31:0] mask_inv;
    logic        mask_ok;
    logic        route_ok;
    logic [16:0] count;
    logic        fam_ok;

    always_comb begin
        b        = i_item.data_byte;
        n_pos    = r_pos;
        n_tlen   = r_tlen;
        n_ihl    = r_ihl;
        n_src    = r_src;
        n_cmd    = r_cmd;
        n_ebi    = r_ebi;
        n_seen   = r_seen;
        n_ws     = r_ws;
        n_addr   = r_addr;
        n_mask   = r_mask;
        n_egood  = r_egood;
        n_bad    = r_bad;
        o_push   = '0;
        mask_inv = ~r_mask;
        mask_ok  = ((mask_inv & (mask_inv + 32'd1)) == 32'd0);
        route_ok = 1'b0;
        fam_ok   = 1'b1;
        count    = {1'b0, r_pos} + 17'd1;

        if (r_pos == POS_VER_IHL) begin
            n_ihl = {b[3:0] & IHL_MASK, 2'b00};
        end
        if (r_pos == POS_LEN_HI) begin
            n_tlen = {b, 8'h00};
        end
        if (r_pos == POS_LEN_LO) begin
            n_tlen = {r_tlen[15:8], b};
        end
        if (r_pos == POS_PROTO && b != PROTO_UDP) begin
            n_bad = 1'b1;
        end
        if (r_pos >= POS_SRC_FRST && r_pos <= POS_SRC_LAST) begin
            n_src = {r_src[23:0], b};
        end

        // RIP header starts after the IP and UDP headers
        rs = 16'({1'b0, n_ihl} + UDP_HDR_BYTES);

        if (r_pos == rs) begin
            n_cmd = b;
            if (b != CMD_REQUEST && b != CMD_RESPONSE) begin
                n_bad = 1'b1;
            end
        end else if (r_pos == rs + 16'd1) begin
            if (b != RIP_VERSION) begin
                n_bad = 1'b1;
            end
        end else if (r_pos == rs + 16'd2 || r_pos == rs + 16'd3) begin
            if (b != 8'd0) begin
                n_bad = 1'b1;
            end
        end else if (r_pos >= rs + 16'(RIP_HDR_BYTES)) begin
            n_ws = {r_ws[23:0], b};
            if (r_ebi == ENT_TAG_END) begin
                if (r_cmd == CMD_REQUEST && n_ws[31:16] != FAMILY_NONE) begin
                    fam_ok = 1'b0;
                end
                if (r_cmd == CMD_RESPONSE && n_ws[31:16] != FAMILY_IP) begin
                    fam_ok = 1'b0;
                end
                n_egood = fam_ok && (n_ws[15:0] == 16'd0);
            end else if (r_ebi == ENT_ADDR_END) begin
                n_addr = n_ws;
            end else if (r_ebi == ENT_MASK_END) begin
                n_mask = n_ws;
            end
            if (r_ebi >= ENTRY_BYTES - 5'd1) begin
                route_ok = r_egood && (n_ws >= 32'd1) && (n_ws <= METRIC_MAX) && mask_ok;
                if (r_seen < CNT_W'(MAX_ENTRIES)) begin
                    o_push.route_vld          = i_valid;
                    o_push.route.result_kind  = KIND_ROUTE;
                    o_push.route.route_addr   = r_addr;
                    o_push.route.route_mask   = r_mask;
                    o_push.route.next_hop     = n_src;
                    o_push.route.route_metric = n_ws;
                    o_push.route.entry_ok     = route_ok;
                    o_push.route.entry_number = r_seen;
                    o_push.route.rip_command  = r_cmd;
                    n_seen = r_seen + CNT_W'(1);
                    if (!route_ok) begin
                        n_bad = 1'b1;
                    end
                end else begin
                    n_bad = 1'b1;
                end
                n_ebi   = '0;
                n_egood = 1'b1;
            end else begin
                n_ebi = r_ebi + 5'd1;
            end
        end

        if (i_item.last_byte) begin
            o_push.stat_vld         = i_valid;
            o_push.stat.result_kind = KIND_STATUS;
            o_push.stat.packet_ok   = !n_bad && (count == {1'b0, n_tlen})
                                      && (count >= {1'b0, rs + 16'(RIP_HDR_BYTES)});
            o_push.stat.rip_command = n_cmd;
            o_push.stat.entry_count = n_seen;
            // Drop all packet state ready for the next packet
            n_pos   = '0;
            n_tlen  = '0;
            n_ihl   = '0;
            n_src   = '0;
            n_cmd   = '0;
            n_ebi   = '0;
            n_seen  = '0;
            n_ws    = '0;
            n_addr  = '0;
            n_mask  = '0;
            n_egood = 1'b1;
            n_bad   = 1'b0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_tlen  <= '0;
            r_ihl   <= '0;
            r_src   <= '0;
            r_cmd   <= '0;
            r_ebi   <= '0;
            r_seen  <= '0;
            r_ws    <= '0;
            r_addr  <= '0;
            r_mask  <= '0;
            r_egood <= 1'b1;
            r_bad   <= 1'b0;
        end else if (i_valid) begin
            r_pos   <= n_pos;
            r_tlen  <= n_tlen;
            r_ihl   <= n_ihl;
            r_src   <= n_src;
            r_cmd   <= n_cmd;
            r_ebi   <= n_ebi;
            r_seen  <= n_seen;
            r_ws    <= n_ws;
            r_addr  <= n_addr;
            r_mask  <= n_mask;
            r_egood <= n_egood;
            r_bad   <= n_bad;
        end
    end

endmodule

// ----- sv/rpp_outq.sv -----
// Result queue of the RIPv2 packet parser: takes up to two results a cycle,
// hands out one per handshake. Depends on rpp_pkg.
module rpp_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rpp_pkg::t_push                  i_push,
    input  logic                            i_pop,
    output logic                            o_valid,
    output rpp_pkg::t_out_item              o_item,
    output logic [rpp_pkg::QCNT_W-1:0]      o_count
);
    import rpp_pkg::*;

    t_out_item           r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, n_wp;
    logic [QPTR_W-1:0]   r_rp, n_rp;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic [QPTR_W-1:0]   wp1;
    logic                pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign o_count = r_cnt;
    assign wp1     = r_wp + QPTR_W'(1);

    always_comb begin
        n_wp  = r_wp + QPTR_W'(i_push.route_vld) + QPTR_W'(i_push.stat_vld);
        n_rp  = r_rp + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(i_push.route_vld) + QCNT_W'(i_push.stat_vld)
                - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.route_vld) begin
            r_q[r_wp] <= i_push.route;
            if (i_push.stat_vld) begin
                r_q[wp1] <= i_push.stat;
            end
        end else if (i_push.stat_vld) begin
            r_q[r_wp] <= i_push.stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- sv/rip_packet_parser.sv -----
// Top level of the RIPv2 packet parser: input stage, parse logic and result queue.
// Depends on rpp_pkg, rpp_parse and rpp_outq.
//
//   channel   direction   handshake                   payload
//   -------   ---------   -------------------------   ---------------------------
//   in        sink        i_in_valid / o_in_ready     i_in_item  (t_in_item)
//   out       source      o_out_valid / i_out_ready   o_out_item (t_out_item)
//
// One byte item a cycle, back to back. An accepted item is parsed while it sits
// in the input register; its results are then written into the queue registers,
// which offer them to the output.
// A byte yields at most two results (route, then status); the queue drains one
// a cycle while i_out_ready is high, and input stalls only while the queue holds more than four results.
// Synchronous active-low reset empties the queue and clears packet state.
module rip_packet_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rpp_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rpp_pkg::t_out_item   o_out_item
);
    import rpp_pkg::*;

    logic               r_in_valid;
    t_in_item           r_in_item;
    t_push              push;
    logic [QCNT_W-1:0]  q_count;
    logic               in_acc;

    // Accept only while the queue can absorb this item and the one in flight
    assign o_in_ready = (q_count <= QCNT_W'(Q_ACCEPT_MAX));
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc;
        end
    end

    // Hold the byte; no reset needed for payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_item;
        end
    end

    rpp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    rpp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_count (q_count)
    );

`ifndef SYNTHESIS
    // A status result comes only from a held last byte
    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.stat_vld |-> (r_in_valid && r_in_item.last_byte))
        else $error("status result without last byte");

    // A route result comes only from a held byte
    a_route_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.route_vld |-> r_in_valid)
        else $error("route result without input item");

    // Queue never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // Input ready only while the queue has room for two more items' results
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (q_count <= QCNT_W'(Q_ACCEPT_MAX)))
        else $error("input ready with queue too full");
`endif

endmodule
